FILE: hw/rtl/ltu_pkg.sv
// ---------------------------------------------------------------------------
// ltu_pkg
// shared types, codes and the sine table generator for the turtle unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ltu_pkg;

   localparam int STACK_DEPTH_DEFAULT = 1024;
   localparam int SINE_BITS_DEFAULT   = 10;
   localparam int QUEUE_DEPTH         = 4;

   localparam logic [7:0] SYM_FORWARD = 8'h46;
   localparam logic [7:0] SYM_PUSH    = 8'h5B;
   localparam logic [7:0] SYM_POP     = 8'h5D;
   localparam logic [7:0] SYM_LEFT    = 8'h2B;
   localparam logic [7:0] SYM_RIGHT   = 8'h2D;

   localparam logic [2:0] OP_NONE    = 3'd0;
   localparam logic [2:0] OP_FORWARD = 3'd1;
   localparam logic [2:0] OP_PUSH    = 3'd2;
   localparam logic [2:0] OP_POP     = 3'd3;
   localparam logic [2:0] OP_LEFT    = 3'd4;
   localparam logic [2:0] OP_RIGHT   = 3'd5;

   localparam logic [1:0] EV_LINE  = 2'd0;
   localparam logic [1:0] EV_TIP   = 2'd1;
   localparam logic [1:0] EV_OVER  = 2'd2;
   localparam logic [1:0] EV_UNDER = 2'd3;

   localparam logic [2:0] REG_STEP_SIZE     = 3'd0;
   localparam logic [2:0] REG_TURN_ANGLE    = 3'd1;
   localparam logic [2:0] REG_START_X       = 3'd2;
   localparam logic [2:0] REG_START_Y       = 3'd3;
   localparam logic [2:0] REG_START_HEADING = 3'd4;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic [2:0] op;
      logic       begin_req;
   } op_type;

   // quarter wave sine entry j in Q16, taylor series evaluated in Q30
   // only ever evaluated at elaboration, into localparams
   function automatic logic [16:0] quarter_value(input int j, input int tbits);
      logic [63:0] x;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] q;
      x    = (HALF_PI_Q30 * 64'(j)) >> (tbits - 2);
      sum  = x;
      term = x;
      for (int k = 0; k < 7; k++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'((2 * k + 2) * (2 * k + 3));
         if ((k % 2) == 0) sum = sum - term;
         else              sum = sum + term;
      end
      q = (sum + 64'd8192) >> 14;
      if (q > 64'd65536) q = 64'd65536;
      return q[16:0];
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ltu_front.sv
// ---------------------------------------------------------------------------
// ltu_front
// symbol decoder and short op queue feeding the execution side
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ltu_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire  [7:0]        req_symbol,
   input  wire               req_begin_req,
   output logic              q_valid,
   output ltu_pkg::op_type   q_data,
   input  wire               q_take
);

   localparam int PTR_W = $clog2(ltu_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ltu_pkg::QUEUE_DEPTH + 1);

   ltu_pkg::op_type       slot_ff [ltu_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   ltu_pkg::op_type       dec;
   logic                  push;
   logic                  accept;

   always_comb begin
      unique case (req_symbol)
         ltu_pkg::SYM_FORWARD: dec.op = ltu_pkg::OP_FORWARD;
         ltu_pkg::SYM_PUSH:    dec.op = ltu_pkg::OP_PUSH;
         ltu_pkg::SYM_POP:     dec.op = ltu_pkg::OP_POP;
         ltu_pkg::SYM_LEFT:    dec.op = ltu_pkg::OP_LEFT;
         ltu_pkg::SYM_RIGHT:   dec.op = ltu_pkg::OP_RIGHT;
         default:              dec.op = ltu_pkg::OP_NONE;
      endcase
      dec.begin_req = req_begin_req;
   end

   assign req_stall = (count_ff == CNT_W'(ltu_pkg::QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   // ignored symbols only matter when they carry a begin
   assign push      = accept && ((dec.op != ltu_pkg::OP_NONE) || dec.begin_req);

   assign q_valid = (count_ff != '0);
   assign q_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(q_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/ltu_back.sv
// ---------------------------------------------------------------------------
// ltu_back
// turtle state, pose stack, sine table and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ltu_back #(
   parameter int STACK_DEPTH     = ltu_pkg::STACK_DEPTH_DEFAULT,
   parameter int SINE_TABLE_BITS = ltu_pkg::SINE_BITS_DEFAULT
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                q_valid,
   input  ltu_pkg::op_type    q_data,
   output logic               q_take,
   input  wire  [15:0]        step_size,
   input  wire  [15:0]        turn_angle,
   input  wire  [31:0]        start_x,
   input  wire  [31:0]        start_y,
   input  wire  [15:0]        start_heading,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [1:0]         rsp_event_kind,
   output logic signed [31:0] rsp_from_x,
   output logic signed [31:0] rsp_from_y,
   output logic signed [31:0] rsp_to_x,
   output logic signed [31:0] rsp_to_y
);

   localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W  = $clog2(STACK_DEPTH);
   localparam int TB      = SINE_TABLE_BITS;
   localparam int QUARTER = (1 << TB) / 4;
   localparam int QW      = TB - 1;

   logic [16:0] qsine [QUARTER + 1];

   for (genvar j = 0; j <= QUARTER; j++) begin : g_tab
      localparam logic [16:0] QVAL = ltu_pkg::quarter_value(j, TB);
      assign qsine[j] = QVAL;
   end

   logic [79:0]       pose_mem [STACK_DEPTH];
   logic [79:0]       rd_ff;

   logic [31:0]       pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   logic [15:0]       heading_ff, heading_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              tip_ff, tip_in;
   logic              pop_wait_ff, pop_wait_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        kind_ff, kind_in;
   logic [31:0]       fx_ff, fx_in, fy_ff, fy_in, tx_ff, tx_in, ty_ff, ty_in;

   logic [31:0]       cur_x, cur_y;
   logic [15:0]       cur_h;
   logic [CNT_W-1:0]  cur_cnt;
   logic              cur_tip;
   logic              go, emit, wr_en, rd_en;
   logic [CNT_W-1:0]  cnt_dec;
   logic [TB-1:0]     sin_idx, cos_idx;
   logic signed [17:0] sin_v, cos_v;
   logic signed [33:0] dx, dy;
   logic [31:0]       nx, ny;

   function automatic logic signed [17:0] sine_at(input logic [TB-1:0] i,
                                                  input logic [16:0] t [QUARTER + 1]);
      logic [TB-3:0] r;
      logic [QW-1:0] idx;
      logic [17:0]   v;
      r = i[TB-3:0];
      if (i[TB-2]) idx = QW'(QUARTER) - QW'(r);
      else         idx = QW'(r);
      v = {1'b0, t[idx]};
      if (i[TB-1]) return -$signed(v);
      else         return $signed(v);
   endfunction

   assign cur_x   = q_data.begin_req ? start_x       : pen_x_ff;
   assign cur_y   = q_data.begin_req ? start_y       : pen_y_ff;
   assign cur_h   = q_data.begin_req ? start_heading : heading_ff;
   assign cur_cnt = q_data.begin_req ? '0            : count_ff;
   assign cur_tip = q_data.begin_req ? 1'b0          : tip_ff;
   assign cnt_dec = cur_cnt - 1'b1;

   assign sin_idx = cur_h[15 -: TB];
   assign cos_idx = sin_idx + TB'(QUARTER);
   assign sin_v   = sine_at(sin_idx, qsine);
   assign cos_v   = sine_at(cos_idx, qsine);
   assign dx      = $signed({2'b00, step_size}) * cos_v;
   assign dy      = $signed({2'b00, step_size}) * sin_v;
   assign nx      = cur_x + dx[31:0];
   assign ny      = cur_y + dy[31:0];

   assign go     = q_valid && !pop_wait_ff && (!rsp_valid_ff || !rsp_stall);
   assign q_take = go;

   always_comb begin
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      heading_in   = heading_ff;
      count_in     = count_ff;
      tip_in       = tip_ff;
      pop_wait_in  = 1'b0;
      emit         = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      kind_in      = kind_ff;
      fx_in        = '0;
      fy_in        = '0;
      tx_in        = '0;
      ty_in        = '0;
      if (pop_wait_ff) begin
         // stacked pose arrives in the cycle after the read
         pen_x_in   = rd_ff[79:48];
         pen_y_in   = rd_ff[47:16];
         heading_in = rd_ff[15:0];
      end else if (go) begin
         pen_x_in   = cur_x;
         pen_y_in   = cur_y;
         heading_in = cur_h;
         count_in   = cur_cnt;
         tip_in     = cur_tip;
         unique case (q_data.op)
            ltu_pkg::OP_FORWARD: begin
               emit     = 1'b1;
               kind_in  = ltu_pkg::EV_LINE;
               fx_in    = cur_x;
               fy_in    = cur_y;
               tx_in    = nx;
               ty_in    = ny;
               pen_x_in = nx;
               pen_y_in = ny;
            end
            ltu_pkg::OP_PUSH: begin
               if (cur_cnt >= CNT_W'(STACK_DEPTH)) begin
                  emit    = 1'b1;
                  kind_in = ltu_pkg::EV_OVER;
               end else begin
                  wr_en    = 1'b1;
                  count_in = cur_cnt + 1'b1;
                  tip_in   = 1'b1;
               end
            end
            ltu_pkg::OP_POP: begin
               if (cur_cnt == '0) begin
                  emit    = 1'b1;
                  kind_in = ltu_pkg::EV_UNDER;
               end else begin
                  if (cur_tip) begin
                     emit    = 1'b1;
                     kind_in = ltu_pkg::EV_TIP;
                     fx_in   = cur_x;
                     fy_in   = cur_y;
                  end
                  tip_in      = 1'b0;
                  count_in    = cnt_dec;
                  rd_en       = 1'b1;
                  pop_wait_in = 1'b1;
               end
            end
            ltu_pkg::OP_LEFT:  heading_in = cur_h + turn_angle;
            ltu_pkg::OP_RIGHT: heading_in = cur_h - turn_angle;
            default: ;
         endcase
      end
      if (emit)                         rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      else                              rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pose_mem[cur_cnt[ADDR_W-1:0]] <= {cur_x, cur_y, cur_h};
      end
      if (rd_en) begin
         rd_ff <= pose_mem[cnt_dec[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         heading_ff   <= '0;
         count_ff     <= '0;
         tip_ff       <= 1'b0;
         pop_wait_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         heading_ff   <= heading_in;
         count_ff     <= count_in;
         tip_ff       <= tip_in;
         pop_wait_ff  <= pop_wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff <= kind_in;
         fx_ff   <= fx_in;
         fy_ff   <= fy_in;
         tx_ff   <= tx_in;
         ty_ff   <= ty_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_from_x     = fx_ff;
   assign rsp_from_y     = fy_ff;
   assign rsp_to_x       = tx_ff;
   assign rsp_to_y       = ty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count above depth");

   a_pop_wait_once: assert property (@(posedge clock) disable iff (reset)
      pop_wait_ff |=> !pop_wait_ff)
      else $error("pop wait longer than one cycle");

   a_no_take_in_wait: assert property (@(posedge clock) disable iff (reset)
      pop_wait_ff |-> !q_take)
      else $error("op taken while pose load pending");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted result not presented");

endmodule

`default_nettype wire

FILE: hw/rtl/lsystem_turtle_interpreter_unit.sv
// ---------------------------------------------------------------------------
// lsystem_turtle_interpreter_unit
// l-system turtle: decodes symbols, moves a q16.16 pen, keeps a pose stack
// ---------------------------------------------------------------------------
// channel   direction  handshake             payload
// req_      in         req_valid/req_stall   symbol, begin_req
// rsp_      out        rsp_valid/rsp_stall   event_kind, from_x/y, to_x/y
// csr_      in/out     apb psel/penable      paddr, pwdata, prdata
//
// one item per cycle while neither side stalls; a pop that restores a pose holds off the
// next op until the registered read of the pose stack memory has returned.
// a four entry op queue between decoder and execution absorbs stalls.
// reset is synchronous; no clearing pass, stack entries are read only once written.
// the result register holds an item while rsp_stall is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsystem_turtle_interpreter_unit #(
   parameter int STACK_DEPTH     = ltu_pkg::STACK_DEPTH_DEFAULT,
   parameter int SINE_TABLE_BITS = ltu_pkg::SINE_BITS_DEFAULT
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [7:0]         req_symbol,
   input  wire                req_begin_req,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [1:0]         rsp_event_kind,
   output logic signed [31:0] rsp_from_x,
   output logic signed [31:0] rsp_from_y,
   output logic signed [31:0] rsp_to_x,
   output logic signed [31:0] rsp_to_y,
   input  wire                csr_psel,
   input  wire                csr_penable,
   input  wire                csr_pwrite,
   input  wire  [4:0]         csr_paddr,
   input  wire  [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic [15:0]     step_size_ff, turn_angle_ff, start_heading_ff;
   logic [31:0]     start_x_ff, start_y_ff;
   logic            wr;
   logic            q_valid, q_take;
   ltu_pkg::op_type q_data;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff     <= 16'd1;
         turn_angle_ff    <= 16'd4096;
         start_x_ff       <= '0;
         start_y_ff       <= '0;
         start_heading_ff <= '0;
      end else if (wr) begin
         case (csr_paddr[4:2])
            ltu_pkg::REG_STEP_SIZE:     step_size_ff     <= csr_pwdata[15:0];
            ltu_pkg::REG_TURN_ANGLE:    turn_angle_ff    <= csr_pwdata[15:0];
            ltu_pkg::REG_START_X:       start_x_ff       <= csr_pwdata;
            ltu_pkg::REG_START_Y:       start_y_ff       <= csr_pwdata;
            ltu_pkg::REG_START_HEADING: start_heading_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         ltu_pkg::REG_STEP_SIZE:     csr_prdata = {16'd0, step_size_ff};
         ltu_pkg::REG_TURN_ANGLE:    csr_prdata = {16'd0, turn_angle_ff};
         ltu_pkg::REG_START_X:       csr_prdata = start_x_ff;
         ltu_pkg::REG_START_Y:       csr_prdata = start_y_ff;
         ltu_pkg::REG_START_HEADING: csr_prdata = {16'd0, start_heading_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   ltu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_symbol    (req_symbol),
      .req_begin_req (req_begin_req),
      .q_valid       (q_valid),
      .q_data        (q_data),
      .q_take        (q_take)
   );

   ltu_back #(
      .STACK_DEPTH     (STACK_DEPTH),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_data         (q_data),
      .q_take         (q_take),
      .step_size      (step_size_ff),
      .turn_angle     (turn_angle_ff),
      .start_x        (start_x_ff),
      .start_y        (start_y_ff),
      .start_heading  (start_heading_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_kind (rsp_event_kind),
      .rsp_from_x     (rsp_from_x),
      .rsp_from_y     (rsp_from_y),
      .rsp_to_x       (rsp_to_x),
      .rsp_to_y       (rsp_to_y)
   );

endmodule

`default_nettype wire
